[rtl/core/tualb_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helpers for the trapped UART access line buffer.
package tualb_pkg;

  localparam int DEVICES      = 4;
  localparam int LINE_DEPTH   = 32;
  localparam int WINDOW_BYTES = 4096;

  localparam int STORE_DEPTH = DEVICES * LINE_DEPTH;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(LINE_DEPTH + 1);

  localparam logic [11:0] TX_REG       = 12'h040;
  localparam logic [11:0] TEST_REG     = 12'h0b4;
  localparam logic [63:0] TX_EMPTY_BIT = 64'h40;
  localparam logic [4:0]  ZERO_REG     = 5'h1f;
  localparam logic [7:0]  NEWLINE      = 8'h0a;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic       we;
    addr_t      waddr;
    logic [7:0] wdata;
    logic       re;
    addr_t      raddr;
  } mem_req_t;

  function automatic addr_t line_addr(input logic [1:0] dev, input cnt_t idx);
    line_addr = ADDR_W'(int'(dev) * LINE_DEPTH + int'(idx));
  endfunction

endpackage

[rtl/core/tualb_line_mem.sv]
`timescale 1ns / 1ps
// Line store memory: one write port, one registered read port.
module tualb_line_mem (
  input  logic               clk,
  input  tualb_pkg::mem_req_t req,
  output logic [7:0]         rd_data
);

  logic [7:0] mem_r [tualb_pkg::STORE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/trapped_uart_access_line_buffer_top.sv]
`timescale 1ns / 1ps
// Top level: trapped UART access decode with per-device transmit line buffer.
// A request without a flush is decoded in S_DECODE, which registers its response.
// A flush of n bytes emits each byte through S_RD (one store read) and S_TX (one strobe),
// then the response from S_RESP; the single store read port sets this sequence.
// busy stays high until the final response; the receiver cannot stall the results.
// Reset clears the sequencer and all fill counts; line store contents are not cleared.
module trapped_uart_access_line_buffer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [24:0] in_syndrome,
  input  logic [11:0] in_offset,
  input  logic [1:0]  in_device,
  input  logic [63:0] in_reg_value,
  output logic        out_valid,
  output logic        out_kind,
  output logic        out_handled,
  output logic        out_reg_write,
  output logic [63:0] out_reg_result,
  output logic [7:0]  out_tx_char,
  output logic [1:0]  out_tx_device,
  output logic        out_last
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_TX     = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic        op_r, valid_r, wide_r;
  logic [4:0]  target_r;
  logic [11:0] off_r;
  logic [1:0]  dev_r;
  logic [31:0] rv_hi_r;
  logic [7:0]  rv_lo_r;

  tualb_pkg::cnt_t idx_r, idx_nxt;
  tualb_pkg::cnt_t len_r, len_nxt;
  tualb_pkg::cnt_t fill_r   [tualb_pkg::DEVICES];
  tualb_pkg::cnt_t fill_nxt [tualb_pkg::DEVICES];

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic        out_handled_r, out_handled_nxt;
  logic        out_reg_write_r, out_reg_write_nxt;
  logic [63:0] out_reg_result_r, out_reg_result_nxt;
  logic [7:0]  out_tx_char_r, out_tx_char_nxt;
  logic [1:0]  out_tx_device_r, out_tx_device_nxt;
  logic        out_last_r, out_last_nxt;

  tualb_pkg::mem_req_t mem_req;
  logic [7:0]          mem_rd;

  logic            accept;
  logic            in_win, dev_ok, is_tx, flush;
  logic [7:0]      ch;
  tualb_pkg::cnt_t cnt_cur, cnt_clamp, cnt_inc;
  logic [63:0]     rd_result;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  tualb_line_mem u_line_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  // decode
  always_comb begin
    in_win  = (32'(off_r) < tualb_pkg::WINDOW_BYTES);
    dev_ok  = (32'(dev_r) < tualb_pkg::DEVICES);
    is_tx   = in_win && (off_r == tualb_pkg::TX_REG) && dev_ok;
    ch      = (target_r != tualb_pkg::ZERO_REG) ? rv_lo_r : 8'h00;
    cnt_cur = dev_ok ? fill_r[dev_r] : '0;
    cnt_clamp = (cnt_cur >= tualb_pkg::CNT_W'(tualb_pkg::LINE_DEPTH)) ?
                tualb_pkg::CNT_W'(tualb_pkg::LINE_DEPTH - 1) : cnt_cur;
    cnt_inc = cnt_clamp + tualb_pkg::CNT_W'(1);
    flush   = (ch == tualb_pkg::NEWLINE) ||
              (cnt_inc >= tualb_pkg::CNT_W'(tualb_pkg::LINE_DEPTH));
    rd_result = wide_r ? 64'h0 : {rv_hi_r, 32'h0};
    if (in_win && (off_r == tualb_pkg::TEST_REG)) begin
      rd_result = rd_result | tualb_pkg::TX_EMPTY_BIT;
    end
  end

  always_comb begin
    mem_req.we    = (state_r == S_DECODE) && valid_r && op_r && is_tx;
    mem_req.waddr = tualb_pkg::line_addr(dev_r, cnt_clamp);
    mem_req.wdata = ch;
    mem_req.re    = (state_r == S_RD);
    mem_req.raddr = tualb_pkg::line_addr(dev_r, idx_r);
  end

  // sequencer
  always_comb begin
    state_nxt          = state_r;
    idx_nxt            = idx_r;
    len_nxt            = len_r;
    fill_nxt           = fill_r;
    out_valid_nxt      = 1'b0;
    out_kind_nxt       = out_kind_r;
    out_handled_nxt    = out_handled_r;
    out_reg_write_nxt  = out_reg_write_r;
    out_reg_result_nxt = out_reg_result_r;
    out_tx_char_nxt    = out_tx_char_r;
    out_tx_device_nxt  = out_tx_device_r;
    out_last_nxt       = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        out_kind_nxt       = 1'b0;
        out_handled_nxt    = valid_r;
        out_reg_write_nxt  = 1'b0;
        out_reg_result_nxt = 64'h0;
        out_tx_char_nxt    = 8'h00;
        out_tx_device_nxt  = 2'd0;
        out_last_nxt       = 1'b1;
        out_valid_nxt      = 1'b1;
        state_nxt          = S_IDLE;
        if (valid_r && !op_r) begin
          out_reg_write_nxt  = 1'b1;
          out_reg_result_nxt = rd_result;
        end else if (valid_r && is_tx) begin
          if (flush) begin
            fill_nxt[dev_r] = '0;
            len_nxt         = cnt_inc;
            idx_nxt         = '0;
            out_valid_nxt   = 1'b0;
            state_nxt       = S_RD;
          end else begin
            fill_nxt[dev_r] = cnt_inc;
          end
        end
      end
      S_RD: begin
        state_nxt = S_TX;
      end
      S_TX: begin
        out_valid_nxt      = 1'b1;
        out_kind_nxt       = 1'b1;
        out_handled_nxt    = 1'b1;
        out_reg_write_nxt  = 1'b0;
        out_reg_result_nxt = 64'h0;
        out_tx_char_nxt    = mem_rd;
        out_tx_device_nxt  = dev_r;
        out_last_nxt       = 1'b0;
        idx_nxt            = idx_r + tualb_pkg::CNT_W'(1);
        state_nxt          = (idx_nxt == len_r) ? S_RESP : S_RD;
      end
      S_RESP: begin
        out_valid_nxt      = 1'b1;
        out_kind_nxt       = 1'b0;
        out_handled_nxt    = 1'b1;
        out_reg_write_nxt  = 1'b0;
        out_reg_result_nxt = 64'h0;
        out_tx_char_nxt    = 8'h00;
        out_tx_device_nxt  = 2'd0;
        out_last_nxt       = 1'b1;
        state_nxt          = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fill_r      <= '{default: '0};
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      valid_r  <= in_syndrome[24];
      target_r <= in_syndrome[20:16];
      wide_r   <= in_syndrome[15];
      off_r    <= in_offset;
      dev_r    <= in_device;
      rv_hi_r  <= in_reg_value[63:32];
      rv_lo_r  <= in_reg_value[7:0];
    end
    idx_r            <= idx_nxt;
    len_r            <= len_nxt;
    out_kind_r       <= out_kind_nxt;
    out_handled_r    <= out_handled_nxt;
    out_reg_write_r  <= out_reg_write_nxt;
    out_reg_result_r <= out_reg_result_nxt;
    out_tx_char_r    <= out_tx_char_nxt;
    out_tx_device_r  <= out_tx_device_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_handled    = out_handled_r;
  assign out_reg_write  = out_reg_write_r;
  assign out_reg_result = out_reg_result_r;
  assign out_tx_char    = out_tx_char_r;
  assign out_tx_device  = out_tx_device_r;
  assign out_last       = out_last_r;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for the trapped UART access line buffer: random and directed requests.
module tb_top;

  localparam logic OP_READ   = 1'b0;
  localparam logic OP_WRITE  = 1'b1;
  localparam logic KIND_RESP = 1'b0;
  localparam logic KIND_TX   = 1'b1;
  localparam int   N_ITEMS   = 420;
  localparam int   DRAIN_CYC = 2 * tualb_pkg::LINE_DEPTH + 16;

  typedef struct {
    logic        op;
    logic [24:0] syndrome;
    logic [11:0] offset;
    logic [1:0]  device;
    logic [63:0] reg_value;
    bit          hold_off;
  } access_t;

  typedef struct {
    logic        kind;
    logic        handled;
    logic        reg_write;
    logic [63:0] reg_result;
    logic [7:0]  tx_char;
    logic [1:0]  tx_device;
    logic        last;
  } uart_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_op = 1'b0;
  logic [24:0] in_syndrome = '0;
  logic [11:0] in_offset = '0;
  logic [1:0]  in_device = '0;
  logic [63:0] in_reg_value = '0;
  logic        out_valid;
  logic        out_kind;
  logic        out_handled;
  logic        out_reg_write;
  logic [63:0] out_reg_result;
  logic [7:0]  out_tx_char;
  logic [1:0]  out_tx_device;
  logic        out_last;

  access_t      access_q[$];
  uart_result_t uart_results_q[$];
  access_t      cur;
  int           gap_left = 0;
  int           sent_cnt = 0;
  int           err_cnt = 0;
  logic [7:0]   line_mem[tualb_pkg::DEVICES][tualb_pkg::LINE_DEPTH];
  int           fill_cnt[tualb_pkg::DEVICES];

  trapped_uart_access_line_buffer_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_syndrome(in_syndrome), .in_offset(in_offset),
    .in_device(in_device), .in_reg_value(in_reg_value),
    .out_valid(out_valid), .out_kind(out_kind), .out_handled(out_handled),
    .out_reg_write(out_reg_write), .out_reg_result(out_reg_result),
    .out_tx_char(out_tx_char), .out_tx_device(out_tx_device), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [24:0] mk_syndrome(bit vld, logic [4:0] rt, bit wide);
    logic [24:0] s;
    s = 25'($urandom);
    s[24] = vld;
    s[20:16] = rt;
    s[15] = wide;
    return s;
  endfunction

  task automatic push_access(logic op, logic [24:0] syn, logic [11:0] off,
                             logic [1:0] dev, logic [63:0] rv, bit hold = 1'b0);
    access_t a;
    a.op = op;
    a.syndrome = syn;
    a.offset = off;
    a.device = dev;
    a.reg_value = rv;
    a.hold_off = hold;
    access_q.push_back(a);
  endtask

  task automatic push_noise();
    logic [11:0] off;
    case ($urandom_range(0, 3))
      0: off = tualb_pkg::TX_REG;
      1: off = tualb_pkg::TEST_REG;
      default: off = 12'($urandom);
    endcase
    push_access(1'($urandom), 25'($urandom), off, 2'($urandom), {$urandom, $urandom});
  endtask

  task automatic push_tx(logic [1:0] dev, logic [7:0] ch, bit hold = 1'b0);
    logic [4:0] rt;
    rt = 5'($urandom_range(0, 30));
    push_access(OP_WRITE, mk_syndrome(1'b1, rt, 1'($urandom)), tualb_pkg::TX_REG, dev,
                {$urandom, 24'($urandom), ch}, hold);
  endtask

  task automatic push_line(logic [1:0] dev, int len, bit with_nl, bit hold);
    logic [7:0] ch;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) == 0) push_noise();
      ch = 8'($urandom);
      if (ch == tualb_pkg::NEWLINE) ch = ch ^ 8'h01;
      if ($urandom_range(0, 15) == 0)
        push_access(OP_WRITE, mk_syndrome(1'b1, tualb_pkg::ZERO_REG, 1'($urandom)),
                    tualb_pkg::TX_REG, dev, {$urandom, $urandom});
      else
        push_tx(dev, ch, hold && (i == 0));
    end
    if (with_nl) push_tx(dev, tualb_pkg::NEWLINE);
  endtask

  task automatic model_uart_access(access_t a);
    uart_result_t r;
    logic [4:0]  rt;
    logic [7:0]  ch;
    logic [63:0] res;
    int          cnt;
    int          dev;
    rt = a.syndrome[20:16];
    dev = int'(a.device);
    r = '{KIND_RESP, 1'b1, 1'b0, 64'h0, 8'h0, 2'h0, 1'b1};
    if (!a.syndrome[24]) begin
      r.handled = 1'b0;
    end else if (a.op == OP_READ) begin
      res = a.syndrome[15] ? 64'h0 : {a.reg_value[63:32], 32'h0};
      if (a.offset == tualb_pkg::TEST_REG) res = res | tualb_pkg::TX_EMPTY_BIT;
      r.reg_write = 1'b1;
      r.reg_result = res;
    end else if (a.offset == tualb_pkg::TX_REG && dev < tualb_pkg::DEVICES) begin
      ch = (rt != tualb_pkg::ZERO_REG) ? a.reg_value[7:0] : 8'h00;
      cnt = fill_cnt[dev];
      if (cnt >= tualb_pkg::LINE_DEPTH) cnt = tualb_pkg::LINE_DEPTH - 1;
      line_mem[dev][cnt] = ch;
      cnt++;
      if (ch == tualb_pkg::NEWLINE || cnt >= tualb_pkg::LINE_DEPTH) begin
        for (int i = 0; i < cnt; i++)
          uart_results_q.push_back('{KIND_TX, 1'b1, 1'b0, 64'h0, line_mem[dev][i],
                                     a.device, 1'b0});
        cnt = 0;
      end
      fill_cnt[dev] = cnt;
    end
    uart_results_q.push_back(r);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      for (int d = 0; d < tualb_pkg::DEVICES; d++) fill_cnt[d] = 0;
    end else begin
      if (start && !busy) begin
        model_uart_access(cur);
        sent_cnt++;
        gap_left = ((sent_cnt / 40) % 3 == 2) ? 0 : $urandom_range(0, 16);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (access_q.size() > 0 &&
                     !(access_q[0].hold_off && uart_results_q.size() > 0)) begin
          cur = access_q.pop_front();
          in_op <= cur.op;
          in_syndrome <= cur.syndrome;
          in_offset <= cur.offset;
          in_device <= cur.device;
          in_reg_value <= cur.reg_value;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    uart_result_t e;
    if (rst_n && out_valid === 1'b1) begin
      if (uart_results_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %b char %h result %h",
                 $time, out_kind, out_tx_char, out_reg_result);
        err_cnt++;
      end else begin
        e = uart_results_q.pop_front();
        check_field("kind", 64'(e.kind), 64'(out_kind));
        check_field("handled", 64'(e.handled), 64'(out_handled));
        check_field("reg_write", 64'(e.reg_write), 64'(out_reg_write));
        check_field("reg_result", e.reg_result, out_reg_result);
        check_field("tx_char", 64'(e.tx_char), 64'(out_tx_char));
        check_field("tx_device", 64'(e.tx_device), 64'(out_tx_device));
        check_field("last", 64'(e.last), 64'(out_last));
      end
    end
  end

  initial begin
    logic [63:0] ones;
    ones = '1;
    // invalid syndromes
    push_access(OP_READ, mk_syndrome(1'b0, 5'd3, 1'b0), tualb_pkg::TEST_REG, 2'd0, ones);
    push_access(OP_WRITE, mk_syndrome(1'b0, 5'd4, 1'b1), tualb_pkg::TX_REG, 2'd1, 64'h0a);
    // reads
    push_access(OP_READ, mk_syndrome(1'b1, 5'd0, 1'b0), tualb_pkg::TEST_REG, 2'd0, ones);
    push_access(OP_READ, mk_syndrome(1'b1, tualb_pkg::ZERO_REG, 1'b1), tualb_pkg::TEST_REG,
                2'd3, ones);
    push_access(OP_READ, mk_syndrome(1'b1, 5'd7, 1'b0), 12'h000, 2'd1, ones);
    push_access(OP_READ, mk_syndrome(1'b1, 5'd7, 1'b1), 12'hfff, 2'd2, ones);
    push_access(OP_READ, mk_syndrome(1'b1, 5'd9, 1'b0), tualb_pkg::TX_REG, 2'd2, 64'h0);
    // writes that do not buffer
    push_access(OP_WRITE, mk_syndrome(1'b1, 5'd1, 1'b0), 12'h044, 2'd0, ones);
    push_access(OP_WRITE, mk_syndrome(1'b1, 5'd1, 1'b1), 12'hfff, 2'd3, 64'h0a);
    // short lines, zero register source and newline flush
    push_access(OP_WRITE, mk_syndrome(1'b1, 5'd5, 1'b0), tualb_pkg::TX_REG, 2'd0, 64'h41);
    push_access(OP_WRITE, mk_syndrome(1'b1, tualb_pkg::ZERO_REG, 1'b0), tualb_pkg::TX_REG,
                2'd0, 64'h55);
    push_access(OP_WRITE, mk_syndrome(1'b1, 5'd2, 1'b1), tualb_pkg::TX_REG, 2'd0, ones);
    push_access(OP_WRITE, mk_syndrome(1'b1, 5'd2, 1'b0), tualb_pkg::TX_REG, 2'd1, 64'h0);
    push_access(OP_WRITE, mk_syndrome(1'b1, tualb_pkg::ZERO_REG, 1'b0), tualb_pkg::TX_REG,
                2'd2, 64'h0a);
    push_access(OP_WRITE, mk_syndrome(1'b1, 5'd30, 1'b0), tualb_pkg::TX_REG, 2'd0, 64'h0a);
    push_access(OP_WRITE, mk_syndrome(1'b1, 5'd0, 1'b1), tualb_pkg::TX_REG, 2'd1,
                64'hffff_ffff_ffff_ff0a);
    push_access(OP_WRITE, mk_syndrome(1'b1, 5'd6, 1'b0), tualb_pkg::TX_REG, 2'd3, 64'h0a);
    push_access(OP_WRITE, mk_syndrome(1'b1, 5'd6, 1'b0), tualb_pkg::TX_REG, 2'd2, 64'h0a);
    // full lines, with and without a trailing newline, then random traffic
    push_line(2'($urandom), tualb_pkg::LINE_DEPTH + 1, 1'b0, 1'b1);
    push_line(2'($urandom), tualb_pkg::LINE_DEPTH, 1'b1, 1'b0);
    while (access_q.size() < N_ITEMS) begin
      if ($urandom_range(0, 9) < 6)
        push_line(2'($urandom),
                  ($urandom_range(0, 5) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8),
                  $urandom_range(0, 2) != 0, $urandom_range(0, 9) == 0);
      else
        push_noise();
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (access_q.size() > 0 || start || uart_results_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0 && uart_results_q.size() == 0) begin
      $display("** trapped_uart_access_line_buffer_top: PASSED **");
    end else begin
      $display("** trapped_uart_access_line_buffer_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** trapped_uart_access_line_buffer_top: FAILED **");
    $finish;
  end

endmodule

[trapped_uart_access_line_buffer_top.f]
rtl/core/tualb_pkg.sv
rtl/core/tualb_line_mem.sv
rtl/core/trapped_uart_access_line_buffer_top.sv
bench/tb_top.sv
